/* rtl/sbsm_pkg.sv */
// ----------------------------------------------------------------------------
// sbsm_pkg
// Shared types and constants for the serial bank-switch mapper.
// ----------------------------------------------------------------------------
`default_nettype none

package sbsm_pkg;

   typedef enum logic [1:0] {
      CMD_REG_WRITE = 2'd0,
      CMD_PRG_READ  = 2'd1,
      CMD_CHR_READ  = 2'd2,
      CMD_CHR_WRITE = 2'd3
   } cmd_type;

   // target register, picked by address bits 14..13 on the fifth write
   typedef enum logic [1:0] {
      REG_CONTROL = 2'd0,
      REG_CHR0    = 2'd1,
      REG_CHR1    = 2'd2,
      REG_PRG     = 2'd3
   } reg_sel_type;

   localparam logic [1:0] CSR_PRG_BANK_COUNT = 2'd0;
   localparam logic [1:0] CSR_CHR_IS_RAM     = 2'd1;

   localparam logic [4:0] PRG_BANK_COUNT_RESET = 5'd16;
   localparam logic [4:0] PRG_BANK_COUNT_MAX   = 5'd16;
   localparam logic [1:0] PRG_MODE_FIX_LAST    = 2'd3;
   localparam logic [1:0] PRG_MODE_FIX_FIRST   = 2'd2;
   localparam logic [1:0] MIRROR_HORIZONTAL    = 2'd3;
   localparam logic [2:0] SHIFT_LAST           = 3'd4;

   typedef struct packed {
      logic [4:0] prg_bank_count;
      logic       chr_is_ram;
      logic [1:0] mirror_mode;
      logic       chr_mode;
      logic [1:0] prg_mode;
      logic [3:0] prg_bank;
      logic [4:0] chr_bank_low;
      logic [4:0] chr_bank_high;
   } map_state_type;

endpackage

`default_nettype wire

/* rtl/sbsm_regs.sv */
// ----------------------------------------------------------------------------
// sbsm_regs
// Serial shifter, mapper register file and configuration registers.
// ----------------------------------------------------------------------------
`default_nettype none

module sbsm_regs (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  wr_en,
   input  wire logic [15:0]           wr_address,
   input  wire logic                  wr_reset_bit,
   input  wire logic                  wr_shift_bit,
   input  wire logic                  csr_wr,
   input  wire logic [1:0]            csr_index,
   input  wire logic [4:0]            csr_data,
   output sbsm_pkg::map_state_type    state,
   output logic [1:0]                 mirror_next,
   output logic                       ctrl_written
);
   import sbsm_pkg::*;

   logic [4:0]    shift_value_ff, shift_value_in;
   logic [2:0]    shift_count_ff, shift_count_in;
   map_state_type state_ff, state_in;
   logic [4:0]    shifted;
   reg_sel_type   sel;

   assign shifted = {wr_shift_bit, shift_value_ff[4:1]};
   assign sel     = reg_sel_type'(wr_address[14:13]);

   always_comb begin
      shift_value_in = shift_value_ff;
      shift_count_in = shift_count_ff;
      state_in       = state_ff;
      ctrl_written   = 1'b0;
      if (wr_en && wr_address[15]) begin
         if (wr_reset_bit) begin
            shift_value_in    = '0;
            shift_count_in    = '0;
            state_in.prg_mode = PRG_MODE_FIX_LAST;
         end else if (shift_count_ff >= SHIFT_LAST) begin
            // fifth bit: commit to the selected register
            shift_value_in = '0;
            shift_count_in = '0;
            unique case (sel)
               REG_CONTROL: begin
                  state_in.mirror_mode = shifted[1:0];
                  state_in.prg_mode    = shifted[3:2];
                  state_in.chr_mode    = shifted[4];
                  ctrl_written         = 1'b1;
               end
               REG_CHR0: state_in.chr_bank_low  = shifted;
               REG_CHR1: state_in.chr_bank_high = shifted;
               REG_PRG:  state_in.prg_bank      = shifted[3:0];
               default:  state_in.prg_bank      = shifted[3:0];
            endcase
         end else begin
            shift_value_in = shifted;
            shift_count_in = shift_count_ff + 3'd1;
         end
      end
      if (csr_wr) begin
         if (csr_index == CSR_PRG_BANK_COUNT) begin
            state_in.prg_bank_count = csr_data;
         end else if (csr_index == CSR_CHR_IS_RAM) begin
            state_in.chr_is_ram = csr_data[0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         shift_value_ff          <= '0;
         shift_count_ff          <= '0;
         state_ff.prg_bank_count <= PRG_BANK_COUNT_RESET;
         state_ff.chr_is_ram     <= 1'b0;
         state_ff.mirror_mode    <= MIRROR_HORIZONTAL;
         state_ff.chr_mode       <= 1'b0;
         state_ff.prg_mode       <= PRG_MODE_FIX_LAST;
         state_ff.prg_bank       <= '0;
         state_ff.chr_bank_low   <= '0;
         state_ff.chr_bank_high  <= '0;
      end else begin
         shift_value_ff <= shift_value_in;
         shift_count_ff <= shift_count_in;
         state_ff       <= state_in;
      end
   end

   assign state       = state_ff;
   assign mirror_next = state_in.mirror_mode;

endmodule

`default_nettype wire

/* rtl/sbsm_xlate.sv */
// ----------------------------------------------------------------------------
// sbsm_xlate
// Program and pattern address translation from the current bank state.
// ----------------------------------------------------------------------------
`default_nettype none

module sbsm_xlate (
   input  wire sbsm_pkg::cmd_type       cmd,
   input  wire logic [15:0]             address,
   input  wire sbsm_pkg::map_state_type state,
   output logic [17:0]                  prg_rom_address,
   output logic [16:0]                  chr_mem_address,
   output logic                         chr_write_enable
);
   import sbsm_pkg::*;

   logic       prg_upper;
   logic [3:0] last_bank;
   logic [3:0] prg_bank_sel;
   logic       chr_upper;
   logic [4:0] chr_bank_sel;
   logic [16:0] chr_mapped;
   logic        is_chr;

   assign prg_upper = address[15] & address[14];
   assign chr_upper = address[12];
   assign is_chr    = (cmd == CMD_CHR_READ) || (cmd == CMD_CHR_WRITE);

   // a zero count acts as one bank, anything past the maximum as the maximum
   always_comb begin
      priority if (state.prg_bank_count == 5'd0) begin
         last_bank = 4'd0;
      end else if (state.prg_bank_count > PRG_BANK_COUNT_MAX) begin
         last_bank = 4'hF;
      end else begin
         last_bank = 4'(state.prg_bank_count - 5'd1);
      end
   end

   always_comb begin
      priority if (state.prg_mode < PRG_MODE_FIX_FIRST) begin
         prg_bank_sel = {state.prg_bank[3:1], prg_upper};
      end else if (state.prg_mode == PRG_MODE_FIX_FIRST) begin
         prg_bank_sel = prg_upper ? state.prg_bank : 4'd0;
      end else begin
         prg_bank_sel = prg_upper ? last_bank : state.prg_bank;
      end
   end

   always_comb begin
      if (!state.chr_mode) begin
         chr_bank_sel = {state.chr_bank_low[4:1], chr_upper};
      end else begin
         chr_bank_sel = chr_upper ? state.chr_bank_high : state.chr_bank_low;
      end
      if (state.chr_is_ram) begin
         chr_mapped = {4'd0, address[12:0]};
      end else begin
         chr_mapped = {chr_bank_sel, address[11:0]};
      end
   end

   assign prg_rom_address  = (cmd == CMD_PRG_READ) ? {prg_bank_sel, address[13:0]} : '0;
   assign chr_mem_address  = is_chr ? chr_mapped : '0;
   assign chr_write_enable = (cmd == CMD_CHR_WRITE) && state.chr_is_ram;

endmodule

`default_nettype wire

/* rtl/serial_bank_switch_mapper_core.sv */
// Pipeline: a request is accepted into the input register, and its result
//   loads into the result register once that register can take it.
// Throughput: one item per cycle while rsp_ready holds; the bank registers
//   are read and updated between the two registers.
// Reset: synchronous, active high; clears the shifter and loads the power-on
//   bank state and configuration defaults. No clearing pass.
// ----------------------------------------------------------------------------
// serial_bank_switch_mapper_core
// Bank-switching mapper: serial register writes and address translation.
// ----------------------------------------------------------------------------
`default_nettype none

module serial_bank_switch_mapper_core (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [1:0]  req_cmd,
   input  wire logic [15:0] req_address,
   input  wire logic [7:0]  req_data,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [17:0]      rsp_prg_rom_address,
   output logic [16:0]      rsp_chr_mem_address,
   output logic             rsp_chr_write_enable,
   output logic [1:0]       rsp_mirroring,
   output logic             rsp_mirroring_changed,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [1:0]  csr_index,
   input  wire logic [4:0]  csr_data
);
   import sbsm_pkg::*;

   logic          s1_valid_ff;
   cmd_type       s1_cmd_ff;
   logic [15:0]   s1_address_ff;
   logic          s1_reset_bit_ff;
   logic          s1_shift_bit_ff;

   logic          rsp_valid_ff;
   logic [17:0]   prg_ff;
   logic [16:0]   chr_ff;
   logic          we_ff;
   logic [1:0]    mirror_ff;
   logic          changed_ff;

   logic          out_load;
   logic          s1_advance;
   logic          req_take;

   map_state_type state;
   logic [1:0]    mirror_next;
   logic          ctrl_written;
   logic [17:0]   prg_in;
   logic [16:0]   chr_in;
   logic          we_in;

   assign out_load   = !rsp_valid_ff || rsp_ready;
   assign s1_advance = s1_valid_ff && out_load;
   assign req_ready  = !s1_valid_ff || out_load;
   assign req_take   = req_valid && req_ready;
   assign csr_ready  = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_ready) begin
         s1_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_cmd_ff       <= cmd_type'(req_cmd);
         s1_address_ff   <= req_address;
         s1_reset_bit_ff <= req_data[7];
         s1_shift_bit_ff <= req_data[0];
      end
   end

   sbsm_regs u_regs (
      .clock        (clock),
      .reset        (reset),
      .wr_en        (s1_advance && (s1_cmd_ff == CMD_REG_WRITE)),
      .wr_address   (s1_address_ff),
      .wr_reset_bit (s1_reset_bit_ff),
      .wr_shift_bit (s1_shift_bit_ff),
      .csr_wr       (csr_valid),
      .csr_index    (csr_index),
      .csr_data     (csr_data),
      .state        (state),
      .mirror_next  (mirror_next),
      .ctrl_written (ctrl_written)
   );

   sbsm_xlate u_xlate (
      .cmd              (s1_cmd_ff),
      .address          (s1_address_ff),
      .state            (state),
      .prg_rom_address  (prg_in),
      .chr_mem_address  (chr_in),
      .chr_write_enable (we_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_load) begin
         rsp_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_advance) begin
         prg_ff     <= prg_in;
         chr_ff     <= chr_in;
         we_ff      <= we_in;
         mirror_ff  <= mirror_next;
         changed_ff <= ctrl_written;
      end
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_prg_rom_address   = prg_ff;
   assign rsp_chr_mem_address   = chr_ff;
   assign rsp_chr_write_enable  = we_ff;
   assign rsp_mirroring         = mirror_ff;
   assign rsp_mirroring_changed = changed_ff;

endmodule

`default_nettype wire

/* rtl/sbsm_checker.sv */
// ----------------------------------------------------------------------------
// sbsm_checker
// Port-level checks on the mapper core, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module sbsm_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [17:0] rsp_prg_rom_address,
   input wire logic [16:0] rsp_chr_mem_address,
   input wire logic        rsp_chr_write_enable,
   input wire logic [1:0]  rsp_mirroring,
   input wire logic        rsp_mirroring_changed
);

   // no response can be pending right after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   // a stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_prg_rom_address)
         && $stable(rsp_chr_mem_address) && $stable(rsp_mirroring))
      else $error("stalled response changed");

   // a control write translates nothing
   a_ctrl_no_xlate: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_mirroring_changed |->
         rsp_prg_rom_address == 18'd0 && rsp_chr_mem_address == 17'd0
         && !rsp_chr_write_enable)
      else $error("control write carried an address");

   // program and pattern translations never appear together
   a_one_space: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_prg_rom_address != 18'd0 |->
         rsp_chr_mem_address == 17'd0 && !rsp_chr_write_enable)
      else $error("program and pattern outputs both set");

   // RAM writes stay inside the 8 KB pattern RAM
   a_ram_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_chr_write_enable |-> rsp_chr_mem_address[16:13] == 4'd0)
      else $error("pattern RAM write out of range");

endmodule

bind serial_bank_switch_mapper_core sbsm_checker u_sbsm_checker (.*);

`default_nettype wire
